FILE: rtl/core/dpb_pkg.sv
// dpb_pkg: shared types, widths, register codes and reset values for the
// depth pixel back-projection core; used by every module in rtl/core
package dpb_pkg;

  localparam int PIX_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W   = 16;
  localparam int PROD_W  = 32;
  localparam int QUO_W   = 24;
  localparam int REM_W   = 16;
  localparam int FRAC_W  = 4;

  localparam int DIV_BITS_PER_STAGE = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR      = 3'd5;

  localparam logic [QUO_W-1:0] POS_LIMIT = 24'h7FFFFF;
  localparam logic [QUO_W-1:0] NEG_LIMIT = 24'h800000;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_col;
    logic [DEPTH_W-1:0] depth_mm;
    logic [COLOR_W-1:0] blue_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [QUO_W-1:0] point_x;
    logic signed [QUO_W-1:0] point_y;
    logic [DEPTH_W-1:0]      point_z;
    logic [COLOR_W-1:0]      blue_out;
    logic [COLOR_W-1:0]      green_out;
    logic [COLOR_W-1:0]      red_out;
    logic                    point_valid;
  } point_t;

  typedef struct packed {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
    logic [CFG_W-1:0] near_limit_mm;
    logic [CFG_W-1:0] far_limit_mm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    focal_x:       16'd9600,
    focal_y:       16'd9600,
    center_x:      16'd5120,
    center_y:      16'd3840,
    near_limit_mm: 16'd100,
    far_limit_mm:  16'd2000
  };

  typedef struct packed {
    logic               in_range;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
  } front_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] work;
  } axis_t;

  typedef struct packed {
    side_t side;
    axis_t ax_x;
    axis_t ax_y;
  } div_t;

endpackage

FILE: rtl/core/dpb_front.sv
// dpb_front: first stage, depth range test and offset from the principal point
// depends on dpb_pkg
module dpb_front (
  input  logic            clk,
  input  logic            en,
  input  dpb_pkg::cfg_t   cfg,
  input  dpb_pkg::pixel_t d,
  output dpb_pkg::front_t q
);

  logic [dpb_pkg::MAG_W-1:0] scaled_x;
  logic [dpb_pkg::MAG_W-1:0] scaled_y;
  logic                      neg_x;
  logic                      neg_y;

  assign scaled_x = {d.pixel_col, {dpb_pkg::FRAC_W{1'b0}}};
  assign scaled_y = {d.pixel_row, {dpb_pkg::FRAC_W{1'b0}}};
  assign neg_x    = scaled_x < cfg.center_x;
  assign neg_y    = scaled_y < cfg.center_y;

  always_ff @(posedge clk) begin
    if (en) begin
      q.side.in_range <= (d.depth_mm > cfg.near_limit_mm) && (d.depth_mm < cfg.far_limit_mm);
      q.side.depth    <= d.depth_mm;
      q.side.blue     <= d.blue_in;
      q.side.green    <= d.green_in;
      q.side.red      <= d.red_in;
      q.neg_x         <= neg_x;
      q.neg_y         <= neg_y;
      q.mag_x         <= neg_x ? (cfg.center_x - scaled_x) : (scaled_x - cfg.center_x);
      q.mag_y         <= neg_y ? (cfg.center_y - scaled_y) : (scaled_y - cfg.center_y);
    end
  end

endmodule

FILE: rtl/core/dpb_mult.sv
// dpb_mult: second stage, offset times depth, split into divider start state
// depends on dpb_pkg
module dpb_mult (
  input  logic            clk,
  input  logic            en,
  input  dpb_pkg::front_t d,
  output dpb_pkg::div_t   q
);

  logic [dpb_pkg::PROD_W-1:0] prod_x;
  logic [dpb_pkg::PROD_W-1:0] prod_y;

  assign prod_x = d.mag_x * d.side.depth;
  assign prod_y = d.mag_y * d.side.depth;

  // dividend is the product shifted up by four fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      q.side      <= d.side;
      q.ax_x.neg  <= d.neg_x;
      q.ax_x.ovf  <= 1'b0;
      q.ax_x.rem  <= dpb_pkg::REM_W'(prod_x[dpb_pkg::PROD_W-1:dpb_pkg::QUO_W-dpb_pkg::FRAC_W]);
      q.ax_x.work <= {prod_x[dpb_pkg::QUO_W-dpb_pkg::FRAC_W-1:0], {dpb_pkg::FRAC_W{1'b0}}};
      q.ax_y.neg  <= d.neg_y;
      q.ax_y.ovf  <= 1'b0;
      q.ax_y.rem  <= dpb_pkg::REM_W'(prod_y[dpb_pkg::PROD_W-1:dpb_pkg::QUO_W-dpb_pkg::FRAC_W]);
      q.ax_y.work <= {prod_y[dpb_pkg::QUO_W-dpb_pkg::FRAC_W-1:0], {dpb_pkg::FRAC_W{1'b0}}};
    end
  end

endmodule

FILE: rtl/core/dpb_div_stage.sv
// dpb_div_stage: one stage of the restoring divider, STEP_BITS quotient bits
// per axis, with overflow detection; depends on dpb_pkg
module dpb_div_stage #(
  parameter int STEP_BITS = dpb_pkg::DIV_BITS_PER_STAGE
) (
  input  logic          clk,
  input  logic          en,
  input  dpb_pkg::cfg_t cfg,
  input  dpb_pkg::div_t d,
  output dpb_pkg::div_t q
);

  function automatic dpb_pkg::axis_t div_step(dpb_pkg::axis_t a,
                                              logic [dpb_pkg::REM_W-1:0] f);
    dpb_pkg::axis_t          r;
    logic [dpb_pkg::REM_W:0] trial;
    logic                    qbit;
    r     = a;
    // quotient too large for the coordinate when the running remainder reaches the divisor
    r.ovf = a.ovf | (a.rem >= f);
    for (int k = 0; k < STEP_BITS; k++) begin
      trial = {r.rem, r.work[dpb_pkg::QUO_W-1]};
      qbit  = trial >= {1'b0, f};
      if (qbit) begin
        r.rem = dpb_pkg::REM_W'(trial - {1'b0, f});
      end else begin
        r.rem = trial[dpb_pkg::REM_W-1:0];
      end
      r.work = {r.work[dpb_pkg::QUO_W-2:0], qbit};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q.side <= d.side;
      q.ax_x <= div_step(d.ax_x, cfg.focal_x);
      q.ax_y <= div_step(d.ax_y, cfg.focal_y);
    end
  end

endmodule

FILE: rtl/core/dpb_back.sv
// dpb_back: last stage, sign, saturation and zeroing of out-of-range points
// depends on dpb_pkg
module dpb_back (
  input  logic            clk,
  input  logic            en,
  input  dpb_pkg::div_t   d,
  output dpb_pkg::point_t q
);

  function automatic logic [dpb_pkg::QUO_W-1:0] sat_axis(dpb_pkg::axis_t a);
    logic [dpb_pkg::QUO_W-1:0] r;
    if (a.neg) begin
      if (a.ovf || (a.work > dpb_pkg::NEG_LIMIT)) begin
        r = dpb_pkg::NEG_LIMIT;
      end else begin
        r = -a.work;
      end
    end else begin
      if (a.ovf || a.work[dpb_pkg::QUO_W-1]) begin
        r = dpb_pkg::POS_LIMIT;
      end else begin
        r = a.work;
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (d.side.in_range) begin
        q.point_x     <= signed'(sat_axis(d.ax_x));
        q.point_y     <= signed'(sat_axis(d.ax_y));
        q.point_z     <= d.side.depth;
        q.blue_out    <= d.side.blue;
        q.green_out   <= d.side.green;
        q.red_out     <= d.side.red;
        q.point_valid <= 1'b1;
      end else begin
        q <= '0;
      end
    end
  end

endmodule

FILE: rtl/core/depth_pixel_backprojection_core.sv
// depth_pixel_backprojection_core: pinhole back-projection of depth pixels
// pipeline of front, multiply, divider and back stages
// throughput one pixel per cycle; a stalled output holds the pipeline only where full
// synchronous active-high rst clears valid bits and loads the register reset values
// depends on dpb_pkg, dpb_front, dpb_mult, dpb_div_stage, dpb_back
module depth_pixel_backprojection_core #(
  parameter int DIV_BITS = dpb_pkg::DIV_BITS_PER_STAGE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  output logic                           pix_stall,
  input  dpb_pkg::pixel_t                pix_data,
  output logic                           pt_valid,
  input  logic                           pt_stall,
  output dpb_pkg::point_t                pt_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpb_pkg::CFG_W-1:0]      cfg_data
);

  localparam int DIV_STAGES = dpb_pkg::QUO_W / DIV_BITS;
  localparam int NUM_STAGES = DIV_STAGES + 3;

  dpb_pkg::cfg_t   cfg;
  dpb_pkg::front_t front_q;
  dpb_pkg::div_t   div_q [0:DIV_STAGES];

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;
  logic [NUM_STAGES-1:0] vld_in;

  // register file, zero focal length stored as one
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= dpb_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpb_pkg::CFG_FOCAL_X:  cfg.focal_x <= (cfg_data == '0) ? dpb_pkg::CFG_W'(1) : cfg_data;
        dpb_pkg::CFG_FOCAL_Y:  cfg.focal_y <= (cfg_data == '0) ? dpb_pkg::CFG_W'(1) : cfg_data;
        dpb_pkg::CFG_CENTER_X: cfg.center_x <= cfg_data;
        dpb_pkg::CFG_CENTER_Y: cfg.center_y <= cfg_data;
        dpb_pkg::CFG_NEAR:     cfg.near_limit_mm <= cfg_data;
        dpb_pkg::CFG_FAR:      cfg.far_limit_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage moves when empty or when the one after it moves
  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !pt_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign vld_in    = {vld[NUM_STAGES-2:0], pix_valid};
  assign pix_stall = !adv[0];
  assign pt_valid  = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (adv & vld_in) | (~adv & vld);
    end
  end

  dpb_front u_front (
    .clk (clk),
    .en  (adv[0]),
    .cfg (cfg),
    .d   (pix_data),
    .q   (front_q)
  );

  dpb_mult u_mult (
    .clk (clk),
    .en  (adv[1]),
    .d   (front_q),
    .q   (div_q[0])
  );

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    dpb_div_stage #(
      .STEP_BITS (DIV_BITS)
    ) u_div (
      .clk (clk),
      .en  (adv[j+2]),
      .cfg (cfg),
      .d   (div_q[j]),
      .q   (div_q[j+1])
    );
  end

  dpb_back u_back (
    .clk (clk),
    .en  (adv[NUM_STAGES-1]),
    .d   (div_q[DIV_STAGES]),
    .q   (pt_data)
  );

`ifndef SYNTH
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall && !(pt_valid && !pt_stall))
      |=> $countones(vld) == $past($countones(vld)) + 1)
    else $error("pipeline occupancy did not grow on a lone request");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!(pix_valid && !pix_stall) && pt_valid && !pt_stall)
      |=> $countones(vld) == $past($countones(vld)) - 1)
    else $error("pipeline occupancy did not shrink on a lone delivery");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    (pt_valid && pt_data.point_valid)
      |-> (pt_data.point_z > cfg.near_limit_mm) && (pt_data.point_z < cfg.far_limit_mm))
    else $error("valid point with depth outside the limits");
`endif

endmodule
